// File: hw/rtl/fps_pkg.sv
// Shared types and constants for the frame playback sequencer.
`timescale 1ns / 1ps

package fps_pkg;

   localparam int TimeWidth   = 32;
   localparam int FrameWidth  = 15;
   localparam int FpsWidth    = 8;
   localparam int PeriodWidth = 20;
   localparam int CorrWidth   = 8;
   localparam int OpWidth     = 3;
   localparam int ModeWidth   = 3;
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 20;
   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 24;

   localparam logic [FpsWidth-1:0]    FpsReset    = 8'd30;
   localparam logic [PeriodWidth-1:0] PeriodReset = 20'd33333;
   localparam logic [CorrWidth-1:0]   CorrReset   = 8'd10;

   // command codes
   localparam logic [OpWidth-1:0] OP_TICK  = 3'd0;
   localparam logic [OpWidth-1:0] OP_PLAY  = 3'd1;
   localparam logic [OpWidth-1:0] OP_PAUSE = 3'd2;
   localparam logic [OpWidth-1:0] OP_LOOP  = 3'd3;
   localparam logic [OpWidth-1:0] OP_STOP  = 3'd4;
   localparam logic [OpWidth-1:0] OP_LIVE  = 3'd5;

   // register indexes
   localparam logic [CsrAddrWidth-1:0] CSR_FRAME_COUNT = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_FPS         = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_PERIOD      = 2'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_CORRECTION  = 2'd3;

   typedef enum logic [ModeWidth-1:0] {
      PB_IDLE  = 3'd0,
      PB_PLAY  = 3'd1,
      PB_PAUSE = 3'd2,
      PB_LOOP  = 3'd3,
      PB_STOP  = 3'd4,
      PB_LIVE  = 3'd5
   } mode_type;

   typedef struct packed {
      logic [FrameWidth-1:0]  frame_count;
      logic [FpsWidth-1:0]    frames_per_second;
      logic [PeriodWidth-1:0] frame_period_us;
      logic [CorrWidth-1:0]   second_correction_us;
   } cfg_type;

   typedef struct packed {
      mode_type               mode;
      logic [TimeWidth-1:0]   last_time;
      logic [FrameWidth-1:0]  frame_idx;
      logic [FpsWidth-1:0]    frame_in_sec;
   } state_type;

   typedef struct packed {
      mode_type              prev_mode;
      logic                  mode_changed;
      logic                  frame_advanced;
      logic [FrameWidth-1:0] frame_number;
      mode_type              mode_now;
   } result_type;

endpackage

// File: hw/rtl/fps_csr.sv
// Configuration registers of the frame playback sequencer.
`timescale 1ns / 1ps

module fps_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fps_pkg::CsrAddrWidth-1:0]  csr_addr,
   input  logic [fps_pkg::CsrDataWidth-1:0]  csr_wdata,
   output fps_pkg::cfg_type                  cfg
);

   fps_pkg::cfg_type cfg_ff;
   fps_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            fps_pkg::CSR_FRAME_COUNT:
               cfg_in.frame_count = csr_wdata[fps_pkg::FrameWidth-1:0];
            fps_pkg::CSR_FPS:
               cfg_in.frames_per_second = csr_wdata[fps_pkg::FpsWidth-1:0];
            fps_pkg::CSR_PERIOD:
               cfg_in.frame_period_us = csr_wdata[fps_pkg::PeriodWidth-1:0];
            fps_pkg::CSR_CORRECTION:
               cfg_in.second_correction_us = csr_wdata[fps_pkg::CorrWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_count          <= '0;
         cfg_ff.frames_per_second    <= fps_pkg::FpsReset;
         cfg_ff.frame_period_us      <= fps_pkg::PeriodReset;
         cfg_ff.second_correction_us <= fps_pkg::CorrReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/fps_step.sv
// Next-state and result logic for one command word.
`timescale 1ns / 1ps

module fps_step (
   input  logic [fps_pkg::OpWidth-1:0]   op,
   input  logic [fps_pkg::TimeWidth-1:0] now_time,
   input  logic                          all_neutral,
   input  fps_pkg::cfg_type              cfg,
   input  fps_pkg::state_type            st,
   output fps_pkg::state_type            st_next,
   output fps_pkg::result_type           res
);

   logic [fps_pkg::TimeWidth-1:0]  elapsed;
   logic [fps_pkg::TimeWidth-1:0]  corr;
   logic [fps_pkg::FrameWidth:0]   idx_inc;
   logic [fps_pkg::FpsWidth-1:0]   fis_inc;
   logic                           due;
   logic                           wrap;
   logic                           sec_end;
   logic                           running;
   logic                           fired;
   logic                           advanced;

   assign elapsed = now_time - st.last_time;
   assign corr    = {{(fps_pkg::TimeWidth-fps_pkg::CorrWidth)
                       {cfg.second_correction_us[fps_pkg::CorrWidth-1]}},
                     cfg.second_correction_us};
   assign due     = (elapsed >= {{(fps_pkg::TimeWidth-fps_pkg::PeriodWidth){1'b0}},
                                 cfg.frame_period_us})
                    && (cfg.frame_count != '0);
   assign idx_inc = {1'b0, st.frame_idx} + {{fps_pkg::FrameWidth{1'b0}}, 1'b1};
   assign wrap    = idx_inc >= {1'b0, cfg.frame_count};
   assign fis_inc = st.frame_in_sec + {{(fps_pkg::FpsWidth-1){1'b0}}, 1'b1};
   // a zero frame rate makes every frame a second boundary
   assign sec_end = fis_inc >= cfg.frames_per_second;
   assign running = (st.mode == fps_pkg::PB_PLAY) || (st.mode == fps_pkg::PB_LOOP);

   always_comb begin
      st_next  = st;
      fired    = 1'b0;
      advanced = 1'b0;
      unique case (op)
         fps_pkg::OP_TICK: begin
            if (running) begin
               if (due) begin
                  advanced = 1'b1;
                  if (wrap) begin
                     st_next.frame_idx    = '0;
                     st_next.frame_in_sec = '0;
                     st_next.last_time    = now_time + corr;
                     // end of animation: loop restarts, play goes idle
                     fired        = 1'b1;
                     st_next.mode = (st.mode == fps_pkg::PB_LOOP) ?
                                    fps_pkg::PB_LOOP : fps_pkg::PB_IDLE;
                  end else begin
                     st_next.frame_idx    = idx_inc[fps_pkg::FrameWidth-1:0];
                     st_next.frame_in_sec = sec_end ? '0 : fis_inc;
                     st_next.last_time    = sec_end ? now_time + corr : now_time;
                  end
               end
            end else if (st.mode == fps_pkg::PB_STOP && all_neutral) begin
               fired        = 1'b1;
               st_next.mode = fps_pkg::PB_IDLE;
            end
         end
         fps_pkg::OP_PLAY, fps_pkg::OP_LOOP: begin
            if (st.mode == fps_pkg::PB_IDLE || st.mode == fps_pkg::PB_PAUSE) begin
               fired             = 1'b1;
               st_next.last_time = now_time;
               st_next.mode      = (op == fps_pkg::OP_PLAY) ?
                                   fps_pkg::PB_PLAY : fps_pkg::PB_LOOP;
            end
         end
         fps_pkg::OP_PAUSE: begin
            if (running) begin
               fired        = 1'b1;
               st_next.mode = fps_pkg::PB_PAUSE;
            end
         end
         fps_pkg::OP_STOP: begin
            if (st.mode != fps_pkg::PB_IDLE && st.mode != fps_pkg::PB_STOP) begin
               fired                = 1'b1;
               st_next.frame_idx    = '0;
               st_next.frame_in_sec = '0;
               st_next.mode         = fps_pkg::PB_STOP;
            end
         end
         fps_pkg::OP_LIVE: begin
            if (st.mode == fps_pkg::PB_IDLE) begin
               fired        = 1'b1;
               st_next.mode = fps_pkg::PB_LIVE;
            end
         end
         default: st_next = st;
      endcase
   end

   assign res.mode_now       = st_next.mode;
   assign res.frame_number   = st_next.frame_idx;
   assign res.frame_advanced = advanced;
   assign res.mode_changed   = fired;
   assign res.prev_mode      = fired ? st.mode : st_next.mode;

endmodule

// File: hw/rtl/frame_playback_sequencer_unit.sv
// Top level of the frame playback sequencer: word registers and state.
`timescale 1ns / 1ps

// Playback mode machine with a drift-corrected frame timer.
// req_ carries one command word: tuser holds the opcode (tick, play, pause,
// loop, stop, live), tdata the microsecond time and the all-neutral flag.
// rsp_ returns exactly one result word per command: mode, frame number,
// frame-advanced and mode-changed flags, and the previous mode.
// csr_ writes the frame count, frame rate, frame period and the signed
// per-second correction; write only while no command is in flight.
// The req_ accepting edge loads the input register; the word then moves on to the
// result register, which drives rsp_tvalid, once that register is free or being drained.
// Throughput: one word per cycle while rsp_tready is high, set by the state update.
// When rsp_tready is low the result register holds, the input register
// fills, and req_tready drops; nothing is lost and flow resumes at full rate.
// Reset (synchronous) empties both registers, puts the mode to idle, clears
// frame time, frame and second position, and loads the default settings.
module frame_playback_sequencer_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fps_pkg::ReqDataWidth-1:0]   req_tdata,  // now_time, all_neutral, zero pad
   input  logic [fps_pkg::OpWidth-1:0]        req_tuser,  // op
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // mode_now, frame_number, frame_advanced, mode_changed, prev_mode, zero pad
   output logic [fps_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  logic                               csr_we,
   input  logic [fps_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  logic [fps_pkg::CsrDataWidth-1:0]   csr_wdata
);

   localparam int ResultWidth = $bits(fps_pkg::result_type);

   fps_pkg::cfg_type    cfg;
   fps_pkg::state_type  st_ff;
   fps_pkg::state_type  st_in;
   fps_pkg::result_type res;

   logic                            in_valid_ff;
   logic [fps_pkg::OpWidth-1:0]     in_op_ff;
   logic [fps_pkg::TimeWidth-1:0]   in_now_ff;
   logic                            in_neutral_ff;
   logic                            out_valid_ff;
   logic [fps_pkg::RspDataWidth-1:0] out_data_ff;
   logic                            advance;
   logic                            req_take;

   fps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fps_step u_step (
      .op          (in_op_ff),
      .now_time    (in_now_ff),
      .all_neutral (in_neutral_ff),
      .cfg         (cfg),
      .st          (st_ff),
      .st_next     (st_in),
      .res         (res)
   );

   // the held word moves on when the result register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         st_ff.mode             <= fps_pkg::PB_IDLE;
         st_ff.last_time        <= '0;
         st_ff.frame_idx        <= '0;
         st_ff.frame_in_sec     <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            st_ff        <= st_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff      <= req_tuser;
         in_now_ff     <= req_tdata[fps_pkg::TimeWidth-1:0];
         in_neutral_ff <= req_tdata[fps_pkg::TimeWidth];
      end
      if (advance) begin
         out_data_ff <= {{(fps_pkg::RspDataWidth-ResultWidth){1'b0}}, res};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: tb/frame_playback_sequencer_unit_tb.sv
// Self-checking testbench for the frame playback sequencer: directed rows, then random phases.
`timescale 1ns / 1ps

module frame_playback_sequencer_unit_tb;

   localparam logic [fps_pkg::OpWidth-1:0] OpSpare6 = 3'd6;
   localparam logic [fps_pkg::OpWidth-1:0] OpSpare7 = 3'd7;
   localparam int ResetCycles = 11;
   localparam int HoldCycles  = 80;
   localparam int StallLimit  = 2000;
   localparam int PhaseWords  = 125;
   localparam int PhaseCount  = 7;

   typedef enum logic { ROW_WORD, ROW_SETUP } row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [fps_pkg::OpWidth-1:0]   op;
      logic [fps_pkg::TimeWidth-1:0] now;
      logic                          neutral;
      logic                          typed;
      fps_pkg::result_type           lit;
      fps_pkg::cfg_type              setup;
   } script_row_type;

   logic                             clock;
   logic                             reset       = 1'b1;
   logic                             req_tvalid  = 1'b0;
   logic                             req_tready;
   logic [fps_pkg::ReqDataWidth-1:0] req_tdata   = '0;  // now_time, all_neutral, zero pad
   logic [fps_pkg::OpWidth-1:0]      req_tuser   = '0;  // op
   logic                             rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   // mode_now, frame_number, frame_advanced, mode_changed, prev_mode, zero pad
   logic [fps_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                             csr_we      = 1'b0;
   logic [fps_pkg::CsrAddrWidth-1:0] csr_addr    = '0;
   logic [fps_pkg::CsrDataWidth-1:0] csr_wdata   = '0;

   frame_playback_sequencer_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // player model state and settings
   fps_pkg::cfg_type                cfg;
   fps_pkg::mode_type               pb_mode;
   logic [fps_pkg::TimeWidth-1:0]   pb_last;
   logic [fps_pkg::FrameWidth-1:0]  pb_frame;
   logic [fps_pkg::FpsWidth-1:0]    pb_fis;

   fps_pkg::result_type pending_status[$];
   fps_pkg::result_type oldest;
   fps_pkg::result_type predicted;
   script_row_type      script[$];
   fps_pkg::cfg_type    phase_cfg[PhaseCount];
   int               err_count = 0;
   int               stall_cycles = 0;
   bit               steady = 1'b0;
   int               hold_ask = 0;
   int               hold_seen = 0;
   logic [fps_pkg::TimeWidth-1:0] wall_us;
   logic [fps_pkg::TimeWidth-1:0] step_us;
   logic [fps_pkg::OpWidth-1:0]   op_pick;
   logic                          neutral_pick;
   int unsigned          per;
   int unsigned          r;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic log_mismatch(input string field, input longint unsigned got,
                               input longint unsigned want);
      $display("%0t: %s got %0h want %0h", $realtime, field, got, want);
      err_count++;
   endtask

   // one command through the player; updates the state and returns the status word
   function automatic fps_pkg::result_type advance_player(
         input logic [fps_pkg::OpWidth-1:0] op,
         input logic [fps_pkg::TimeWidth-1:0] now,
         input logic neutral);
      fps_pkg::result_type res;
      fps_pkg::mode_type   start_mode;
      logic       fired;
      logic       adv;
      logic       second_done;
      logic [fps_pkg::TimeWidth-1:0] elapsed;
      logic [fps_pkg::FrameWidth:0]  nxt;
      logic [fps_pkg::FpsWidth-1:0]  fis_n;
      start_mode = pb_mode;
      fired = 1'b0;
      adv = 1'b0;
      case (op)
         fps_pkg::OP_TICK: begin
            if (pb_mode == fps_pkg::PB_PLAY || pb_mode == fps_pkg::PB_LOOP) begin
               elapsed = now - pb_last;
               if (elapsed >= cfg.frame_period_us && cfg.frame_count != '0) begin
                  adv = 1'b1;
                  pb_last = now;
                  nxt = {1'b0, pb_frame} + 1'b1;
                  if (nxt >= {1'b0, cfg.frame_count}) begin
                     pb_frame = '0;
                     pb_fis = '0;
                     second_done = 1'b1;
                  end else begin
                     pb_frame = nxt[fps_pkg::FrameWidth-1:0];
                     fis_n = pb_fis + 1'b1;
                     // a rate of zero lands here on every frame
                     second_done = fis_n >= cfg.frames_per_second;
                     pb_fis = second_done ? '0 : fis_n;
                  end
                  if (second_done)
                     pb_last = pb_last + {{24{cfg.second_correction_us[7]}},
                                          cfg.second_correction_us};
                  if (pb_frame == '0) begin
                     fired = 1'b1;
                     if (pb_mode != fps_pkg::PB_LOOP) pb_mode = fps_pkg::PB_IDLE;
                  end
               end
            end else if (pb_mode == fps_pkg::PB_STOP && neutral) begin
               fired = 1'b1;
               pb_mode = fps_pkg::PB_IDLE;
            end
         end
         fps_pkg::OP_PLAY, fps_pkg::OP_LOOP: begin
            if (pb_mode == fps_pkg::PB_IDLE || pb_mode == fps_pkg::PB_PAUSE) begin
               pb_last = now;
               fired = 1'b1;
               if (op == fps_pkg::OP_PLAY) pb_mode = fps_pkg::PB_PLAY;
               else pb_mode = fps_pkg::PB_LOOP;
            end
         end
         fps_pkg::OP_PAUSE: begin
            if (pb_mode == fps_pkg::PB_PLAY || pb_mode == fps_pkg::PB_LOOP) begin
               fired = 1'b1;
               pb_mode = fps_pkg::PB_PAUSE;
            end
         end
         fps_pkg::OP_STOP: begin
            if (pb_mode != fps_pkg::PB_IDLE && pb_mode != fps_pkg::PB_STOP) begin
               pb_frame = '0;
               pb_fis = '0;
               fired = 1'b1;
               pb_mode = fps_pkg::PB_STOP;
            end
         end
         fps_pkg::OP_LIVE: begin
            if (pb_mode == fps_pkg::PB_IDLE) begin
               fired = 1'b1;
               pb_mode = fps_pkg::PB_LIVE;
            end
         end
         default: ;
      endcase
      res.mode_now = pb_mode;
      res.frame_number = pb_frame;
      res.frame_advanced = adv;
      res.mode_changed = fired;
      res.prev_mode = fired ? start_mode : pb_mode;
      return res;
   endfunction

   function automatic script_row_type word_row(input logic [fps_pkg::OpWidth-1:0] op,
                                               input logic [fps_pkg::TimeWidth-1:0] now,
                                               input logic neutral);
      script_row_type row;
      row = '0;
      row.kind = ROW_WORD;
      row.op = op;
      row.now = now;
      row.neutral = neutral;
      return row;
   endfunction

   function automatic script_row_type lit_row(input logic [fps_pkg::OpWidth-1:0] op,
                                              input logic [fps_pkg::TimeWidth-1:0] now,
                                              input logic neutral,
                                              input fps_pkg::mode_type m,
                                              input logic chg,
                                              input fps_pkg::mode_type pm);
      script_row_type row;
      row = word_row(op, now, neutral);
      row.typed = 1'b1;
      row.lit.mode_now = m;
      row.lit.frame_number = '0;
      row.lit.frame_advanced = 1'b0;
      row.lit.mode_changed = chg;
      row.lit.prev_mode = pm;
      return row;
   endfunction

   function automatic script_row_type setup_row(input fps_pkg::cfg_type c);
      script_row_type row;
      row = '0;
      row.kind = ROW_SETUP;
      row.setup = c;
      return row;
   endfunction

   task automatic load_settings(input fps_pkg::cfg_type c);
      csr_we <= 1'b1;
      csr_addr <= fps_pkg::CSR_FRAME_COUNT;
      csr_wdata <= fps_pkg::CsrDataWidth'(c.frame_count);
      @(posedge clock);
      csr_addr <= fps_pkg::CSR_FPS;
      csr_wdata <= fps_pkg::CsrDataWidth'(c.frames_per_second);
      @(posedge clock);
      csr_addr <= fps_pkg::CSR_PERIOD;
      csr_wdata <= c.frame_period_us;
      @(posedge clock);
      csr_addr <= fps_pkg::CSR_CORRECTION;
      csr_wdata <= fps_pkg::CsrDataWidth'(c.second_correction_us);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg = c;
   endtask

   // returns at the edge where the word is taken
   task automatic offer_word(input logic [fps_pkg::OpWidth-1:0] op,
                             input logic [fps_pkg::TimeWidth-1:0] now,
                             input logic neutral);
      while (!steady && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, neutral, now};
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         rsp_tready <= steady || ($urandom_range(99) >= 22);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_status.size() == 0) begin
            log_mismatch("unexpected word", rsp_tdata, 0);
         end else begin
            oldest = pending_status.pop_front();
            if (rsp_tdata[2:0] != oldest.mode_now)
               log_mismatch("mode_now", rsp_tdata[2:0], oldest.mode_now);
            if (rsp_tdata[17:3] != oldest.frame_number)
               log_mismatch("frame_number", rsp_tdata[17:3], oldest.frame_number);
            if (rsp_tdata[18] != oldest.frame_advanced)
               log_mismatch("frame_advanced", rsp_tdata[18], oldest.frame_advanced);
            if (rsp_tdata[19] != oldest.mode_changed)
               log_mismatch("mode_changed", rsp_tdata[19], oldest.mode_changed);
            if (rsp_tdata[22:20] != oldest.prev_mode)
               log_mismatch("prev_mode", rsp_tdata[22:20], oldest.prev_mode);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= StallLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      cfg = '{15'd0, fps_pkg::FpsReset, fps_pkg::PeriodReset, fps_pkg::CorrReset};
      pb_mode = fps_pkg::PB_IDLE;
      pb_last = '0;
      pb_frame = '0;
      pb_fis = '0;

      // reset settings: zero frame count, so play never advances
      script.push_back(lit_row(fps_pkg::OP_TICK,  32'h0,         1'b0,
                               fps_pkg::PB_IDLE,  1'b0, fps_pkg::PB_IDLE));
      script.push_back(lit_row(OpSpare6,          32'h0,         1'b0,
                               fps_pkg::PB_IDLE,  1'b0, fps_pkg::PB_IDLE));
      script.push_back(lit_row(OpSpare7,          32'hFFFF_FFFF, 1'b1,
                               fps_pkg::PB_IDLE,  1'b0, fps_pkg::PB_IDLE));
      script.push_back(lit_row(fps_pkg::OP_PAUSE, 32'h0,         1'b0,
                               fps_pkg::PB_IDLE,  1'b0, fps_pkg::PB_IDLE));
      script.push_back(lit_row(fps_pkg::OP_STOP,  32'h0,         1'b1,
                               fps_pkg::PB_IDLE,  1'b0, fps_pkg::PB_IDLE));
      script.push_back(lit_row(fps_pkg::OP_PLAY,  32'h0,         1'b0,
                               fps_pkg::PB_PLAY,  1'b1, fps_pkg::PB_IDLE));
      script.push_back(lit_row(fps_pkg::OP_TICK,  32'hFFFF_FFFF, 1'b1,
                               fps_pkg::PB_PLAY,  1'b0, fps_pkg::PB_PLAY));
      script.push_back(lit_row(fps_pkg::OP_LOOP,  32'h0,         1'b0,
                               fps_pkg::PB_PLAY,  1'b0, fps_pkg::PB_PLAY));
      script.push_back(lit_row(fps_pkg::OP_PAUSE, 32'h0,         1'b0,
                               fps_pkg::PB_PAUSE, 1'b1, fps_pkg::PB_PLAY));
      script.push_back(lit_row(fps_pkg::OP_TICK,  32'h0,         1'b1,
                               fps_pkg::PB_PAUSE, 1'b0, fps_pkg::PB_PAUSE));
      script.push_back(lit_row(fps_pkg::OP_STOP,  32'h0,         1'b0,
                               fps_pkg::PB_STOP,  1'b1, fps_pkg::PB_PAUSE));
      script.push_back(lit_row(fps_pkg::OP_TICK,  32'h0,         1'b0,
                               fps_pkg::PB_STOP,  1'b0, fps_pkg::PB_STOP));
      script.push_back(lit_row(fps_pkg::OP_TICK,  32'h0,         1'b1,
                               fps_pkg::PB_IDLE,  1'b1, fps_pkg::PB_STOP));
      script.push_back(lit_row(fps_pkg::OP_LIVE,  32'h0,         1'b0,
                               fps_pkg::PB_LIVE,  1'b1, fps_pkg::PB_IDLE));
      script.push_back(lit_row(fps_pkg::OP_PLAY,  32'h0,         1'b1,
                               fps_pkg::PB_LIVE,  1'b0, fps_pkg::PB_LIVE));
      script.push_back(lit_row(fps_pkg::OP_STOP,  32'h0,         1'b0,
                               fps_pkg::PB_STOP,  1'b1, fps_pkg::PB_LIVE));
      script.push_back(lit_row(fps_pkg::OP_TICK,  32'h0,         1'b1,
                               fps_pkg::PB_IDLE,  1'b1, fps_pkg::PB_STOP));
      // three frames, two per second, shortest period, most negative correction
      script.push_back(setup_row('{15'd3, 8'd2, 20'd3922, 8'h80}));
      script.push_back(word_row(fps_pkg::OP_LOOP,  32'hFFFF_FA00, 1'b0));
      script.push_back(word_row(fps_pkg::OP_TICK,  32'h0000_0951, 1'b0));  // one short of a period
      script.push_back(word_row(fps_pkg::OP_TICK,  32'h0000_0952, 1'b0));  // elapsed wraps past zero
      script.push_back(word_row(fps_pkg::OP_TICK,  32'h0000_18A4, 1'b0));  // second boundary
      script.push_back(word_row(fps_pkg::OP_TICK,  32'h0000_3000, 1'b0));  // loop restart
      script.push_back(word_row(fps_pkg::OP_PAUSE, 32'h0000_3800, 1'b0));
      script.push_back(word_row(fps_pkg::OP_PLAY,  32'h0000_4000, 1'b0));
      script.push_back(word_row(fps_pkg::OP_TICK,  32'h0000_5000, 1'b0));
      script.push_back(word_row(fps_pkg::OP_TICK,  32'h0000_6000, 1'b0));
      script.push_back(word_row(fps_pkg::OP_TICK,  32'h0000_7000, 1'b0));  // play ends at wrap

      phase_cfg[0] = '{15'd5, 8'd2, 20'd3922, 8'h80};
      phase_cfg[1] = '{15'd1, 8'd1, 20'd1000000, 8'h7F};
      phase_cfg[2] = '{15'd32767, 8'd255, 20'd3922, 8'h00};
      phase_cfg[3] = '{15'd0, 8'd30, 20'd33333, 8'd10};
      phase_cfg[4] = '{15'd12, 8'd0, 20'hFFFFF, 8'hFF};
      phase_cfg[5].frame_count = 15'($urandom_range(40, 2));
      phase_cfg[5].frames_per_second = 8'($urandom_range(8, 1));
      phase_cfg[5].frame_period_us = 20'($urandom_range(60000, 3922));
      phase_cfg[5].second_correction_us = 8'($urandom_range(255));
      phase_cfg[6] = '{15'd7, 8'd3, 20'd4000, 8'h80};

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_SETUP) begin
            settle();
            load_settings(script[i].setup);
         end else begin
            offer_word(script[i].op, script[i].now, script[i].neutral);
            predicted = advance_player(script[i].op, script[i].now, script[i].neutral);
            pending_status.push_back(script[i].typed ? script[i].lit : predicted);
         end
      end

      wall_us = $urandom;
      for (int p = 0; p < PhaseCount; p++) begin
         settle();
         load_settings(phase_cfg[p]);
         steady = (p == 2);
         if (p == PhaseCount - 1) hold_ask++;
         per = 32'(cfg.frame_period_us);
         repeat (PhaseWords) begin
            r = $urandom_range(99);
            if (r < 70) step_us = per + $urandom_range(per / 8);
            else if (r < 85) step_us = $urandom_range(per - 1);
            else if (r < 95) step_us = $urandom_range(3);
            else step_us = $urandom;
            wall_us = wall_us + step_us;
            r = $urandom_range(99);
            if (r < 62) op_pick = fps_pkg::OP_TICK;
            else if (r < 71) op_pick = fps_pkg::OP_PLAY;
            else if (r < 79) op_pick = fps_pkg::OP_LOOP;
            else if (r < 86) op_pick = fps_pkg::OP_PAUSE;
            else if (r < 93) op_pick = fps_pkg::OP_STOP;
            else if (r < 97) op_pick = fps_pkg::OP_LIVE;
            else if (r < 98) op_pick = OpSpare6;
            else op_pick = OpSpare7;
            neutral_pick = 1'($urandom_range(1));
            offer_word(op_pick, wall_us, neutral_pick);
            pending_status.push_back(advance_player(op_pick, wall_us, neutral_pick));
         end
      end
      steady = 1'b0;
      settle();

      if (err_count == 0 && pending_status.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
